>>> sv/bgbi_pkg.sv
package bgbi_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int SCALE_W  = 12;
  localparam int CELLS_W  = 4;
  localparam int EMPTY_W  = 10;
  localparam int LEVEL_W  = 7;
  localparam int BDIV_W   = 8;
  localparam int PAUSE_W  = 10;
  localparam int VOLT_W   = 16;
  localparam int COUNT_W  = 16;

  // Shared divider: dividend sized for scale * sample, divisor for a sample
  localparam int DVD_W = SCALE_W + SAMPLE_W;
  localparam int DVS_W = SAMPLE_W;
  localparam int STEP_W = $clog2(DVD_W + 1);

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_SCALE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_IN_SERIES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CELL_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LEVEL        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LEVEL       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_DIVISOR    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TICKS      = 3'd6;

  // Register reset values
  localparam logic [SCALE_W-1:0] RST_VOLTAGE_SCALE    = 12'd684;
  localparam logic [CELLS_W-1:0] RST_CELLS_IN_SERIES  = 4'd4;
  localparam logic [EMPTY_W-1:0] RST_EMPTY_CELL_LEVEL = 10'd330;
  localparam logic [LEVEL_W-1:0] RST_RUN_LEVEL        = 7'd25;
  localparam logic [LEVEL_W-1:0] RST_STOP_LEVEL       = 7'd20;
  localparam logic [BDIV_W-1:0]  RST_BLINK_DIVISOR    = 8'd5;
  localparam logic [PAUSE_W-1:0] RST_PAUSE_TICKS      = 10'd60;

  localparam logic [LEVEL_W-1:0] CHARGE_FULL = 7'd100;

  // Divider operand selection
  localparam logic [1:0] DIV_VOLT = 2'd0;
  localparam logic [1:0] DIV_CELL = 2'd1;
  localparam logic [1:0] DIV_MOD  = 2'd2;

  typedef struct packed {
    logic [SCALE_W-1:0] voltage_scale;
    logic [CELLS_W-1:0] cells_in_series;
    logic [EMPTY_W-1:0] empty_cell_level;
    logic [LEVEL_W-1:0] run_level;
    logic [LEVEL_W-1:0] stop_level;
    logic [BDIV_W-1:0]  blink_divisor;
    logic [PAUSE_W-1:0] pause_ticks;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic       capture;
    logic       dump_wr;
    logic       div_start;
    logic [1:0] div_sel;
    logic       pack_wr;
    logic       charge_wr;
    logic       blink_wr;
    logic       out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic measure;
    logic ref_zero;
    logic div_done;
  } sts_t;

endpackage

>>> sv/bgbi_in_if.sv
interface bgbi_in_if import bgbi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [SAMPLE_W-1:0] battery_sample;
  logic [SAMPLE_W-1:0] reference_sample;

  modport source (output valid, command, battery_sample, reference_sample, input ready);
  modport sink   (input valid, command, battery_sample, reference_sample, output ready);
endinterface

>>> sv/bgbi_out_if.sv
interface bgbi_out_if import bgbi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               led_off;
  logic               buzzer_on;
  logic               dump_on;
  logic [LEVEL_W-1:0] charge_level;
  logic [VOLT_W-1:0]  pack_voltage;
  logic               reference_fault;

  modport source (output valid, led_off, buzzer_on, dump_on, charge_level, pack_voltage,
                  reference_fault, input ready);
  modport sink   (input valid, led_off, buzzer_on, dump_on, charge_level, pack_voltage,
                  reference_fault, output ready);
endinterface

>>> sv/bgbi_div.sv
module bgbi_div import bgbi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  logic [DVD_W-1:0]  dvd_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W-1:0]  rem_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;

  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  diff;
  logic              ge;

  // One restoring step: bring down the next dividend bit, try to subtract
  assign shifted = {rem_r, dvd_r[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign ge      = ~diff[DVS_W+1];

  assign done      = busy_r && (cnt_r == '0);
  assign quotient  = dvd_r;
  assign remainder = rem_r;

  // Control: count the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= STEP_W'(DVD_W);
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Operands, shifted one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r && (cnt_r != '0)) begin
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

endmodule

>>> sv/bgbi_dp.sv
module bgbi_dp import bgbi_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                in_command,
  input  logic [SAMPLE_W-1:0] in_battery_sample,
  input  logic [SAMPLE_W-1:0] in_reference_sample,
  output logic                o_led_off,
  output logic                o_buzzer_on,
  output logic                o_dump_on,
  output logic [LEVEL_W-1:0]  o_charge_level,
  output logic [VOLT_W-1:0]   o_pack_voltage,
  output logic                o_reference_fault
);

  // Captured item
  logic                command_r;
  logic [SAMPLE_W-1:0] bat_r;
  logic [SAMPLE_W-1:0] ref_r;

  // Gauge state
  logic [VOLT_W-1:0]  pack_r;
  logic [LEVEL_W-1:0] charge_r;
  logic [COUNT_W-1:0] count_r;
  logic               led_r;
  logic               buzzer_r;
  logic               dump_r;

  // Result payload
  logic               led_off_r;
  logic               buzzer_on_r;
  logic               dump_on_r;
  logic [LEVEL_W-1:0] charge_level_r;
  logic [VOLT_W-1:0]  pack_voltage_r;
  logic               fault_r;

  logic [DVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic               div_done;
  logic [DVD_W-1:0]   div_q;
  logic [DVS_W-1:0]   div_rem;
  logic [CELLS_W-1:0] cells_eff;
  logic [BDIV_W-1:0]  bdiv_eff;
  logic               fault;
  logic [VOLT_W-1:0]  cell_v;
  logic [VOLT_W-1:0]  cell_diff;
  logic [LEVEL_W-1:0] charge_nxt;
  logic [COUNT_W:0]   pause_end;

  assign fault = command_r && (ref_r == '0);

  assign sts.measure  = command_r;
  assign sts.ref_zero = (ref_r == '0);
  assign sts.div_done = div_done;

  // A zero count or divisor acts as one
  assign cells_eff = (cfg.cells_in_series == '0) ? CELLS_W'(1) : cfg.cells_in_series;
  assign bdiv_eff  = (cfg.blink_divisor == '0) ? BDIV_W'(1) : cfg.blink_divisor;

  // Divider operands
  always_comb begin
    unique case (cmd.div_sel)
      DIV_VOLT: begin
        div_dvd = DVD_W'(cfg.voltage_scale) * DVD_W'(bat_r);
        div_dvs = ref_r;
      end
      DIV_CELL: begin
        div_dvd = DVD_W'(pack_r);
        div_dvs = DVS_W'(cells_eff);
      end
      DIV_MOD: begin
        div_dvd = DVD_W'(count_r);
        div_dvs = DVS_W'(bdiv_eff);
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  bgbi_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // Charge from cell voltage, clamped to 0..100
  assign cell_v    = div_q[VOLT_W-1:0];
  assign cell_diff = cell_v - VOLT_W'(cfg.empty_cell_level);
  always_comb begin
    if (cell_v <= VOLT_W'(cfg.empty_cell_level)) begin
      charge_nxt = '0;
    end else if (cell_diff > VOLT_W'(CHARGE_FULL)) begin
      charge_nxt = CHARGE_FULL;
    end else begin
      charge_nxt = cell_diff[LEVEL_W-1:0];
    end
  end

  assign pause_end = (COUNT_W+1)'(charge_r) + (COUNT_W+1)'(cfg.pause_ticks);

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      command_r <= in_command;
      bat_r     <= in_battery_sample;
      ref_r     <= in_reference_sample;
    end
  end

  // Gauge state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_r   <= '0;
      charge_r <= '0;
      count_r  <= '0;
      led_r    <= 1'b1;
      buzzer_r <= 1'b0;
      dump_r   <= 1'b0;
    end else begin
      // hysteretic load switch, run test first
      if (cmd.dump_wr) begin
        if (charge_r >= cfg.run_level) begin
          dump_r <= 1'b1;
        end else if (charge_r < cfg.stop_level) begin
          dump_r <= 1'b0;
        end
      end
      if (cmd.pack_wr) begin
        pack_r <= (div_q[DVD_W-1:VOLT_W] != '0) ? '1 : div_q[VOLT_W-1:0];
      end
      if (cmd.charge_wr) begin
        charge_r <= charge_nxt;
        count_r  <= count_r + 1'b1;
      end
      // blink sequence, then pause, then restart; at zero charge, blink with buzzer
      if (cmd.blink_wr) begin
        if (charge_r != '0) begin
          buzzer_r <= 1'b0;
          if (count_r < COUNT_W'(charge_r)) begin
            if (div_rem == '0) begin
              led_r <= ~led_r;
            end
          end else if ((COUNT_W+1)'(count_r) < pause_end) begin
            led_r <= 1'b1;
          end else begin
            count_r <= '0;
          end
        end else begin
          led_r    <= ~led_r;
          buzzer_r <= 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      led_off_r      <= led_r;
      buzzer_on_r    <= buzzer_r;
      dump_on_r      <= dump_r;
      charge_level_r <= charge_r;
      pack_voltage_r <= pack_r;
      fault_r        <= fault;
    end
  end

  assign o_led_off         = led_off_r;
  assign o_buzzer_on       = buzzer_on_r;
  assign o_dump_on         = dump_on_r;
  assign o_charge_level    = charge_level_r;
  assign o_pack_voltage    = pack_voltage_r;
  assign o_reference_fault = fault_r;

endmodule

>>> sv/bgbi_ctrl.sv
module bgbi_ctrl import bgbi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHK    = 3'd1;
  localparam logic [2:0] S_VWAIT  = 3'd2;
  localparam logic [2:0] S_CWAIT  = 3'd3;
  localparam logic [2:0] S_MSTART = 3'd4;
  localparam logic [2:0] S_MWAIT  = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequencer
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.measure) begin
          cmd.dump_wr = 1'b1;
          if (sts.ref_zero) begin
            state_nxt = S_FIN;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_VOLT;
            state_nxt     = S_VWAIT;
          end
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_CELL;
          state_nxt     = S_CWAIT;
        end
      end
      S_VWAIT: begin
        if (sts.div_done) begin
          cmd.pack_wr = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_CWAIT: begin
        if (sts.div_done) begin
          cmd.charge_wr = 1'b1;
          state_nxt     = S_MSTART;
        end
      end
      S_MSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MOD;
        state_nxt     = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts.div_done) begin
          cmd.blink_wr = 1'b1;
          state_nxt    = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result slot occupancy
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/battery_gauge_blink_indicator.sv
// Battery gauge with blink-count charge indicator and hysteretic load switch.
// in_ch carries one tick per item: command 1 is a measure tick that takes
// battery_sample and reference_sample, command 0 is a display tick.
// out_ch returns exactly one result item per tick: LED level, buzzer, dump
// switch, charge in percent, pack voltage in centivolts and reference fault.
// Both channels use valid/ready; an item moves when both are high.
// Items are handled one at a time by a shared 24-step restoring divider.
// Measure tick: one division (pack voltage), none with a zero reference.
// Display tick: two divisions (cell voltage, blink phase). in_ch.ready rises
// the cycle after the result is loaded, so a new item may be taken while a
// result still waits.
// A stalled receiver holds the result in the output register; the next item
// then completes its work and waits until the output register is free.
// Reset (rst_n low, synchronous) sets config and gauge state to defaults:
// zero voltage and charge, LED off, buzzer and dump off, no result pending.
// Registers are written over the cfg_ port at byte address 4*index and
// should only be written while the block is idle.
module battery_gauge_blink_indicator import bgbi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bgbi_in_if.sink               in_ch,
  bgbi_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t                 cfg_r;
  cmd_t                 cmd;
  sts_t                 sts;
  logic                 cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  // Register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.voltage_scale    <= RST_VOLTAGE_SCALE;
      cfg_r.cells_in_series  <= RST_CELLS_IN_SERIES;
      cfg_r.empty_cell_level <= RST_EMPTY_CELL_LEVEL;
      cfg_r.run_level        <= RST_RUN_LEVEL;
      cfg_r.stop_level       <= RST_STOP_LEVEL;
      cfg_r.blink_divisor    <= RST_BLINK_DIVISOR;
      cfg_r.pause_ticks      <= RST_PAUSE_TICKS;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_VOLTAGE_SCALE:    cfg_r.voltage_scale    <= cfg_pwdata[SCALE_W-1:0];
        REG_CELLS_IN_SERIES:  cfg_r.cells_in_series  <= cfg_pwdata[CELLS_W-1:0];
        REG_EMPTY_CELL_LEVEL: cfg_r.empty_cell_level <= cfg_pwdata[EMPTY_W-1:0];
        REG_RUN_LEVEL:        cfg_r.run_level        <= cfg_pwdata[LEVEL_W-1:0];
        REG_STOP_LEVEL:       cfg_r.stop_level       <= cfg_pwdata[LEVEL_W-1:0];
        REG_BLINK_DIVISOR:    cfg_r.blink_divisor    <= cfg_pwdata[BDIV_W-1:0];
        REG_PAUSE_TICKS:      cfg_r.pause_ticks      <= cfg_pwdata[PAUSE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      REG_VOLTAGE_SCALE:    cfg_prdata = CFG_DATA_W'(cfg_r.voltage_scale);
      REG_CELLS_IN_SERIES:  cfg_prdata = CFG_DATA_W'(cfg_r.cells_in_series);
      REG_EMPTY_CELL_LEVEL: cfg_prdata = CFG_DATA_W'(cfg_r.empty_cell_level);
      REG_RUN_LEVEL:        cfg_prdata = CFG_DATA_W'(cfg_r.run_level);
      REG_STOP_LEVEL:       cfg_prdata = CFG_DATA_W'(cfg_r.stop_level);
      REG_BLINK_DIVISOR:    cfg_prdata = CFG_DATA_W'(cfg_r.blink_divisor);
      REG_PAUSE_TICKS:      cfg_prdata = CFG_DATA_W'(cfg_r.pause_ticks);
      default:              cfg_prdata = '0;
    endcase
  end

  bgbi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bgbi_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_command          (in_ch.command),
    .in_battery_sample   (in_ch.battery_sample),
    .in_reference_sample (in_ch.reference_sample),
    .o_led_off           (out_ch.led_off),
    .o_buzzer_on         (out_ch.buzzer_on),
    .o_dump_on           (out_ch.dump_on),
    .o_charge_level      (out_ch.charge_level),
    .o_pack_voltage      (out_ch.pack_voltage),
    .o_reference_fault   (out_ch.reference_fault)
  );

endmodule

>>> test/battery_gauge_blink_indicator_tb.sv
`timescale 1ns / 1ps

module battery_gauge_blink_indicator_tb;
  import bgbi_pkg::*;

  // Index beyond the register file, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic CMD_DISPLAY = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;
  localparam int PHASE_ITEMS = 195;

  typedef struct packed {
    logic               led_off;
    logic               buzzer_on;
    logic               dump_on;
    logic [LEVEL_W-1:0] charge_level;
    logic [VOLT_W-1:0]  pack_voltage;
    logic               reference_fault;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  bgbi_in_if  in_ch ();
  bgbi_out_if out_ch ();

  battery_gauge_blink_indicator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Register mirror
  logic [SCALE_W-1:0] scale_r = RST_VOLTAGE_SCALE;
  logic [CELLS_W-1:0] cells_r = RST_CELLS_IN_SERIES;
  logic [EMPTY_W-1:0] empty_r = RST_EMPTY_CELL_LEVEL;
  logic [LEVEL_W-1:0] run_r   = RST_RUN_LEVEL;
  logic [LEVEL_W-1:0] stop_r  = RST_STOP_LEVEL;
  logic [BDIV_W-1:0]  bdiv_r  = RST_BLINK_DIVISOR;
  logic [PAUSE_W-1:0] pause_r = RST_PAUSE_TICKS;

  // Gauge state mirror
  logic [VOLT_W-1:0]  pack_cv = '0;
  logic [LEVEL_W-1:0] charge_pct = '0;
  logic [COUNT_W-1:0] blink_count = '0;
  logic               led_level = 1'b1;
  logic               buzz_level = 1'b0;
  logic               dump_level = 1'b0;

  reading_t    pending_readings[$];
  int          err_cnt = 0;
  bit          send_gaps = 1'b1;
  bit          rx_stalls = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned target_cell = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the gauge by one tick and return the reading it should give
  function automatic reading_t gauge_step(logic cmd, logic [SAMPLE_W-1:0] bat,
                                          logic [SAMPLE_W-1:0] ref_smp);
    reading_t    rd;
    int unsigned quot, cells_n, div_n, cell_cv, chg;
    rd.reference_fault = 1'b0;
    if (cmd == CMD_MEASURE) begin
      if (ref_smp == '0) begin
        rd.reference_fault = 1'b1;
      end else begin
        quot = (32'(scale_r) * 32'(bat)) / 32'(ref_smp);
        pack_cv = (quot > 32'd65535) ? 16'hFFFF : quot[VOLT_W-1:0];
      end
      // run test first, so an inverted band favours switching on
      if (charge_pct >= run_r) begin
        dump_level = 1'b1;
      end else if (charge_pct < stop_r) begin
        dump_level = 1'b0;
      end
    end else begin
      cells_n = (cells_r == '0) ? 32'd1 : 32'(cells_r);
      div_n   = (bdiv_r == '0) ? 32'd1 : 32'(bdiv_r);
      cell_cv = 32'(pack_cv) / cells_n;
      chg = (cell_cv <= 32'(empty_r)) ? 32'd0 : cell_cv - 32'(empty_r);
      if (chg > 32'd100) chg = 32'd100;
      charge_pct = chg[LEVEL_W-1:0];
      blink_count = blink_count + 1'b1;
      if (charge_pct != '0) begin
        if (32'(blink_count) < 32'(charge_pct)) begin
          if (32'(blink_count) % div_n == 0) led_level = ~led_level;
        end else if (32'(blink_count) < 32'(charge_pct) + 32'(pause_r)) begin
          led_level = 1'b1;
        end else begin
          blink_count = '0;
        end
        buzz_level = 1'b0;
      end else begin
        led_level = ~led_level;
        buzz_level = 1'b1;
      end
    end
    rd.led_off      = led_level;
    rd.buzzer_on    = buzz_level;
    rd.dump_on      = dump_level;
    rd.charge_level = charge_pct;
    rd.pack_voltage = pack_cv;
    return rd;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned exp_v);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, field, got, exp_v);
    err_cnt++;
  endtask

  // Offer one tick; valid is left high so a following item needs no gap
  task automatic send_tick(logic cmd, logic [SAMPLE_W-1:0] bat, logic [SAMPLE_W-1:0] ref_smp);
    int gap;
    gap = (send_gaps && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 11)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.command          <= cmd;
    in_ch.battery_sample   <= bat;
    in_ch.reference_sample <= ref_smp;
    do @(posedge clk); while (!in_ch.ready);
    pending_readings.push_back(gauge_step(cmd, bat, ref_smp));
  endtask

  // Stop offering and wait for every outstanding reading
  task automatic drain_readings();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_VOLTAGE_SCALE:    scale_r = value[SCALE_W-1:0];
      REG_CELLS_IN_SERIES:  cells_r = value[CELLS_W-1:0];
      REG_EMPTY_CELL_LEVEL: empty_r = value[EMPTY_W-1:0];
      REG_RUN_LEVEL:        run_r   = value[LEVEL_W-1:0];
      REG_STOP_LEVEL:       stop_r  = value[LEVEL_W-1:0];
      REG_BLINK_DIVISOR:    bdiv_r  = value[BDIV_W-1:0];
      REG_PAUSE_TICKS:      pause_r = value[PAUSE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_config(int unsigned scale, int unsigned cells, int unsigned empty,
                            int unsigned run, int unsigned stop, int unsigned bdiv,
                            int unsigned pause);
    write_reg(REG_VOLTAGE_SCALE, scale);
    write_reg(REG_CELLS_IN_SERIES, cells);
    write_reg(REG_EMPTY_CELL_LEVEL, empty);
    write_reg(REG_RUN_LEVEL, run);
    write_reg(REG_STOP_LEVEL, stop);
    write_reg(REG_BLINK_DIVISOR, bdiv);
    write_reg(REG_PAUSE_TICKS, pause);
    // stray write, must leave everything as it was
    write_reg(REG_UNUSED, $urandom());
  endtask

  // Mostly display ticks; most measures aim near the interesting charge band
  task automatic random_tick();
    int unsigned pick, cells_n, scale_n, ref_v, want, bat_v;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      send_tick(CMD_DISPLAY, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
    end else if (pick < 75) begin
      send_tick(CMD_MEASURE, SAMPLE_W'($urandom()), '0);
    end else if (pick < 83) begin
      send_tick(CMD_MEASURE, SAMPLE_W'($urandom()), SAMPLE_W'($urandom_range(1, 4095)));
    end else begin
      cells_n = (cells_r == '0) ? 32'd1 : 32'(cells_r);
      scale_n = (scale_r == '0) ? 32'd1 : 32'(scale_r);
      ref_v = $urandom_range(1, 4095);
      if ($urandom_range(0, 9) < 7) begin
        want = target_cell + $urandom_range(0, 4);
      end else begin
        want = 32'(empty_r) + $urandom_range(0, 125);
        want = (want > 10) ? want - 10 : 0;
      end
      // round up so the truncated quotient lands on the wanted level
      bat_v = (want * cells_n * ref_v + scale_n - 1) / scale_n;
      if (bat_v > 32'd4095) bat_v = 32'd4095;
      send_tick(CMD_MEASURE, bat_v[SAMPLE_W-1:0], ref_v[SAMPLE_W-1:0]);
    end
  endtask

  task automatic run_phase();
    target_cell = 32'(empty_r) + $urandom_range(1, 100);
    repeat (PHASE_ITEMS) random_tick();
    drain_readings();
  endtask

  task automatic test_measure_extremes();
    send_tick(CMD_MEASURE, 12'd100, 12'd0);       // zero reference
    send_tick(CMD_DISPLAY, 12'd0, 12'd0);         // zero charge, buzzer
    send_tick(CMD_MEASURE, 12'hFFF, 12'd1);       // saturation
    send_tick(CMD_MEASURE, 12'd0, 12'hFFF);
    send_tick(CMD_MEASURE, 12'hFFF, 12'hFFF);
    send_tick(CMD_MEASURE, 12'h800, 12'h7FF);
    send_tick(CMD_MEASURE, 12'hAAA, 12'h555);     // cell level a little over empty
  endtask

  task automatic test_blink_sequence();
    repeat (12) send_tick(CMD_DISPLAY, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
  endtask

  task automatic test_dump_hysteresis();
    send_tick(CMD_MEASURE, 12'd1440, 12'd684);
    send_tick(CMD_DISPLAY, 12'd0, 12'd0);
    send_tick(CMD_MEASURE, 12'd1408, 12'd684);    // above run level, switch on
    send_tick(CMD_DISPLAY, 12'd0, 12'd0);
    send_tick(CMD_MEASURE, 12'd1408, 12'd684);    // inside the band, holds
    drain_readings();
  endtask

  task automatic test_default_gauge();
    run_phase();
  endtask

  // Receiver holds off while ticks keep coming, then the sender waits it out
  task automatic test_back_pressure();
    hold_req = 1'b1;
    repeat (10) random_tick();
    drain_readings();
  endtask

  task automatic test_config_corners();
    set_config(4095, 8, 1000, 100, 100, 255, 1023);
    run_phase();
    set_config(1, 1, 0, 0, 0, 1, 0);
    run_phase();
    // zero cell count and zero blink divisor
    set_config(2000, 0, 500, 60, 30, 0, 10);
    run_phase();
    // run level below stop level
    set_config(1200, 3, 300, 20, 80, 3, 200);
    run_phase();
    set_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom());
    run_phase();
  endtask

  task automatic test_full_rate();
    send_gaps = 1'b0;
    rx_stalls = 1'b0;
    set_config($urandom_range(400, 1500), $urandom_range(1, 8), $urandom_range(200, 400),
               $urandom_range(0, 100), $urandom_range(0, 100), $urandom_range(1, 12),
               $urandom_range(0, 80));
    run_phase();
  endtask

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b1;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
    end
  end

  // Compare each reading with the oldest prediction
  always @(posedge clk) begin : check_readings
    reading_t exp_rd;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected reading, pack_voltage", out_ch.pack_voltage, 0);
      end else begin
        exp_rd = pending_readings.pop_front();
        if (out_ch.led_off !== exp_rd.led_off)
          report_mismatch("led_off", out_ch.led_off, exp_rd.led_off);
        if (out_ch.buzzer_on !== exp_rd.buzzer_on)
          report_mismatch("buzzer_on", out_ch.buzzer_on, exp_rd.buzzer_on);
        if (out_ch.dump_on !== exp_rd.dump_on)
          report_mismatch("dump_on", out_ch.dump_on, exp_rd.dump_on);
        if (out_ch.charge_level !== exp_rd.charge_level)
          report_mismatch("charge_level", out_ch.charge_level, exp_rd.charge_level);
        if (out_ch.pack_voltage !== exp_rd.pack_voltage)
          report_mismatch("pack_voltage", out_ch.pack_voltage, exp_rd.pack_voltage);
        if (out_ch.reference_fault !== exp_rd.reference_fault)
          report_mismatch("reference_fault", out_ch.reference_fault, exp_rd.reference_fault);
      end
    end
  end

  initial begin
    #15_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    in_ch.valid            = 1'b0;
    in_ch.command          = CMD_DISPLAY;
    in_ch.battery_sample   = '0;
    in_ch.reference_sample = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_measure_extremes();
    test_blink_sequence();
    test_dump_hysteresis();
    test_default_gauge();
    test_back_pressure();
    test_config_corners();
    test_full_rate();

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
